@@ rtl/gclst_pkg.sv @@
package gclst_pkg;

    // attempt tag counter width, 8 to 32
    localparam int ATTEMPT_BITS = 32;
    localparam logic [31:0] TAG_MASK = 32'((64'd1 << ATTEMPT_BITS) - 64'd1);

    localparam logic [3:0] EV_BEGIN_REG    = 4'd0;
    localparam logic [3:0] EV_REGISTERED   = 4'd1;
    localparam logic [3:0] EV_BEGIN_OPEN   = 4'd2;
    localparam logic [3:0] EV_BEGIN_CANCEL = 4'd3;
    localparam logic [3:0] EV_OPENED       = 4'd4;
    localparam logic [3:0] EV_OPEN_FAIL    = 4'd5;
    localparam logic [3:0] EV_CANCELLED    = 4'd6;
    localparam logic [3:0] EV_BEGIN_CLOSE  = 4'd7;
    localparam logic [3:0] EV_DISCONNECTED = 4'd8;
    localparam logic [3:0] EV_RESET        = 4'd9;

    localparam logic [1:0] OUTCOME_IGNORED   = 2'd0;
    localparam logic [1:0] OUTCOME_CONNECTED = 2'd1;
    localparam logic [1:0] OUTCOME_LATE      = 2'd2;

    localparam logic CFG_IFACE  = 1'b0;
    localparam logic CFG_HANDLE = 1'b1;

    typedef struct packed {
        logic [3:0]  mode;
        logic [7:0]  interface_id;
        logic [31:0] attempt_tag;
        logic [15:0] connection_handle;
    } event_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  open_outcome;
        logic [31:0] issued_attempt;
        logic [2:0]  link_state;
        logic [7:0]  current_interface;
        logic [15:0] current_connection;
        logic [31:0] current_attempt;
    } result_t;

endpackage

@@ rtl/gclst_fsm.sv @@
module gclst_fsm
    import gclst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        step,
    input  event_t      ev,
    output result_t     res
);

    typedef enum logic [2:0] {
        PH_UNREG       = 3'd0,
        PH_REGISTERING = 3'd1,
        PH_IDLE        = 3'd2,
        PH_OPENING     = 3'd3,
        PH_CANCELLING  = 3'd4,
        PH_CONNECTED   = 3'd5,
        PH_CLOSING     = 3'd6
    } phase_t;

    logic [7:0]  inv_iface_reg;
    logic [15:0] inv_handle_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  iface_reg, iface_next;
    logic [15:0] conn_reg, conn_next;
    logic [31:0] active_reg, active_next;
    logic [31:0] next_tag_reg, next_tag_next;

    logic        acc;
    logic [1:0]  outcome;
    logic [31:0] issued;
    logic        tag_ok;
    logic [31:0] bumped;
    logic [31:0] advanced;

    assign tag_ok   = (ev.attempt_tag != 32'd0) && (ev.attempt_tag == active_reg);
    assign bumped   = (next_tag_reg + 32'd1) & TAG_MASK;
    // counter skips zero on wrap
    assign advanced = (bumped == 32'd0) ? 32'd1 : bumped;

    always_comb
    begin
        phase_next    = phase_reg;
        iface_next    = iface_reg;
        conn_next     = conn_reg;
        active_next   = active_reg;
        next_tag_next = next_tag_reg;
        acc           = 1'b0;
        outcome       = OUTCOME_IGNORED;
        issued        = 32'd0;
        unique case (ev.mode)
            EV_BEGIN_REG:
            begin
                if (phase_reg == PH_UNREG)
                begin
                    phase_next = PH_REGISTERING;
                    acc        = 1'b1;
                end
            end
            EV_REGISTERED:
            begin
                if (phase_reg == PH_REGISTERING && ev.interface_id != inv_iface_reg)
                begin
                    iface_next = ev.interface_id;
                    phase_next = PH_IDLE;
                    acc        = 1'b1;
                end
            end
            EV_BEGIN_OPEN:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    active_next   = next_tag_reg;
                    next_tag_next = advanced;
                    phase_next    = PH_OPENING;
                    issued        = next_tag_reg;
                    acc           = 1'b1;
                end
            end
            EV_BEGIN_CANCEL:
            begin
                if (phase_reg == PH_OPENING && tag_ok)
                begin
                    phase_next = PH_CANCELLING;
                    acc        = 1'b1;
                end
            end
            EV_OPENED:
            begin
                if (tag_ok && ev.connection_handle != inv_handle_reg)
                begin
                    if (phase_reg == PH_OPENING)
                    begin
                        conn_next  = ev.connection_handle;
                        phase_next = PH_CONNECTED;
                        outcome    = OUTCOME_CONNECTED;
                        acc        = 1'b1;
                    end
                    else if (phase_reg == PH_CANCELLING)
                    begin
                        // open won the race with the cancel, go straight to closing
                        conn_next  = ev.connection_handle;
                        phase_next = PH_CLOSING;
                        outcome    = OUTCOME_LATE;
                        acc        = 1'b1;
                    end
                end
            end
            EV_OPEN_FAIL:
            begin
                if (tag_ok && (phase_reg == PH_OPENING || phase_reg == PH_CANCELLING))
                begin
                    conn_next  = inv_handle_reg;
                    phase_next = PH_IDLE;
                    acc        = 1'b1;
                end
            end
            EV_CANCELLED:
            begin
                if (phase_reg == PH_CANCELLING && tag_ok)
                begin
                    conn_next  = inv_handle_reg;
                    phase_next = PH_IDLE;
                    acc        = 1'b1;
                end
            end
            EV_BEGIN_CLOSE:
            begin
                if (phase_reg == PH_CONNECTED && conn_reg == ev.connection_handle)
                begin
                    phase_next = PH_CLOSING;
                    acc        = 1'b1;
                end
            end
            EV_DISCONNECTED:
            begin
                if ((phase_reg == PH_CONNECTED || phase_reg == PH_CLOSING)
                    && conn_reg == ev.connection_handle)
                begin
                    conn_next  = inv_handle_reg;
                    phase_next = PH_IDLE;
                    acc        = 1'b1;
                end
            end
            EV_RESET:
            begin
                phase_next    = PH_UNREG;
                iface_next    = inv_iface_reg;
                conn_next     = inv_handle_reg;
                active_next   = 32'd0;
                next_tag_next = advanced;
                acc           = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.accepted           = acc;
        res.open_outcome       = outcome;
        res.issued_attempt     = issued;
        res.link_state         = phase_next;
        res.current_interface  = iface_next;
        res.current_connection = conn_next;
        res.current_attempt    = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_iface_reg  <= 8'hFF;
            inv_handle_reg <= 16'hFFFF;
            phase_reg      <= PH_UNREG;
            iface_reg      <= 8'hFF;
            conn_reg       <= 16'hFFFF;
            active_reg     <= 32'd0;
            next_tag_reg   <= 32'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_IFACE:  inv_iface_reg  <= cfg_data[7:0];
                    CFG_HANDLE: inv_handle_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (step)
            begin
                phase_reg    <= phase_next;
                iface_reg    <= iface_next;
                conn_reg     <= conn_next;
                active_reg   <= active_next;
                next_tag_reg <= next_tag_next;
            end
        end
    end

endmodule

@@ rtl/gclst_out_stage.sv @@
module gclst_out_stage
    import gclst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     res,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00,
                       res_reg.current_attempt,
                       res_reg.current_connection,
                       res_reg.current_interface,
                       res_reg.link_state,
                       res_reg.issued_attempt,
                       res_reg.open_outcome,
                       res_reg.accepted};

endmodule

@@ rtl/gatt_client_link_state_tracker.sv @@
// channel  | signals                           | contents
// ---------+-----------------------------------+-----------------------------------------
// events   | s_tvalid s_tready s_tdata s_tuser | tuser: mode; tdata: id, tag, handle
// results  | m_tvalid m_tready m_tdata         | accepted, outcome, issued tag, state
// config   | cfg_we cfg_addr cfg_data          | 0 invalid interface id, 1 invalid handle
//
// one item per cycle while the result side is not stalled; an item waits in the input
// register, and the state update happens as it moves into the result register, where
// the result is held valid until it is taken
// rst_n clears state to unregistered and the sentinels to all ones
// a stalled result holds the input register; ready drops only when both are full
module gatt_client_link_state_tracker
    import gclst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // interface_id, attempt_tag, connection_handle
    input  logic [3:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // accepted, open_outcome, issued_attempt, link_state,
                                   // current_interface, current_connection,
                                   // current_attempt, zero fill
);

    logic    in_valid_reg, in_valid_next;
    event_t  ev_reg;
    logic    step;
    logic    take;
    result_t res;

    assign step     = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        priority if (take)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ev_reg.mode              <= s_tuser;
            ev_reg.interface_id      <= s_tdata[7:0];
            ev_reg.attempt_tag       <= s_tdata[39:8];
            ev_reg.connection_handle <= s_tdata[55:40];
        end
    end

    gclst_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .step     (step),
        .ev       (ev_reg),
        .res      (res)
    );

    gclst_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ test/tb_gatt_client_link_state_tracker.sv @@
module tb_gatt_client_link_state_tracker;
    import gclst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        LS_UNREG,
        LS_REGISTERING,
        LS_IDLE,
        LS_OPENING,
        LS_CANCELLING,
        LS_CONNECTED,
        LS_CLOSING
    } link_state_e;

    class link_scoreboard;
        logic [7:0]  bad_iface;
        logic [15:0] bad_handle;
        link_state_e phase;
        logic [7:0]  iface;
        logic [15:0] conn;
        logic [31:0] active_tag;
        logic [31:0] next_tag;
        result_t     pending[$];
        int unsigned events_noted;
        int unsigned accepted_count;
        int unsigned late_connects;
        int unsigned results_checked;
        int unsigned errors;

        function void clear_link();
            phase      = LS_UNREG;
            iface      = bad_iface;
            conn       = bad_handle;
            active_tag = '0;
        endfunction

        function void power_on();
            bad_iface  = 8'hFF;
            bad_handle = 16'hFFFF;
            clear_link();
            next_tag = 32'd1;
        endfunction

        function void write_reg(logic addr, logic [15:0] data);
            if (addr == CFG_IFACE)
                bad_iface = data[7:0];
            else
                bad_handle = data;
        endfunction

        // tag counter wraps at the counter width and never hands out zero
        function void bump_tag();
            next_tag = (next_tag + 32'd1) & TAG_MASK;
            if (next_tag == '0)
                next_tag = 32'd1;
        endfunction

        function bit tag_hit(logic [31:0] tag);
            return tag != '0 && tag == active_tag;
        endfunction

        function void note_event(event_t ev);
            result_t want;
            want = '0;
            case (ev.mode)
                EV_BEGIN_REG:
                    if (phase == LS_UNREG)
                    begin
                        phase = LS_REGISTERING;
                        want.accepted = 1'b1;
                    end
                EV_REGISTERED:
                    if (phase == LS_REGISTERING && ev.interface_id != bad_iface)
                    begin
                        iface = ev.interface_id;
                        phase = LS_IDLE;
                        want.accepted = 1'b1;
                    end
                EV_BEGIN_OPEN:
                    if (phase == LS_IDLE)
                    begin
                        active_tag = next_tag;
                        bump_tag();
                        phase = LS_OPENING;
                        want.issued_attempt = active_tag;
                        want.accepted = 1'b1;
                    end
                EV_BEGIN_CANCEL:
                    if (phase == LS_OPENING && tag_hit(ev.attempt_tag))
                    begin
                        phase = LS_CANCELLING;
                        want.accepted = 1'b1;
                    end
                EV_OPENED:
                    if (tag_hit(ev.attempt_tag) && ev.connection_handle != bad_handle)
                    begin
                        if (phase == LS_OPENING)
                        begin
                            conn = ev.connection_handle;
                            phase = LS_CONNECTED;
                            want.open_outcome = OUTCOME_CONNECTED;
                            want.accepted = 1'b1;
                        end
                        else if (phase == LS_CANCELLING)
                        begin
                            // connect raced the cancel: go straight to closing
                            conn = ev.connection_handle;
                            phase = LS_CLOSING;
                            want.open_outcome = OUTCOME_LATE;
                            want.accepted = 1'b1;
                            late_connects++;
                        end
                    end
                EV_OPEN_FAIL:
                    if (tag_hit(ev.attempt_tag) &&
                        (phase == LS_OPENING || phase == LS_CANCELLING))
                    begin
                        conn = bad_handle;
                        phase = LS_IDLE;
                        want.accepted = 1'b1;
                    end
                EV_CANCELLED:
                    if (phase == LS_CANCELLING && tag_hit(ev.attempt_tag))
                    begin
                        conn = bad_handle;
                        phase = LS_IDLE;
                        want.accepted = 1'b1;
                    end
                EV_BEGIN_CLOSE:
                    if (phase == LS_CONNECTED && conn == ev.connection_handle)
                    begin
                        phase = LS_CLOSING;
                        want.accepted = 1'b1;
                    end
                EV_DISCONNECTED:
                    if ((phase == LS_CONNECTED || phase == LS_CLOSING) &&
                        conn == ev.connection_handle)
                    begin
                        conn = bad_handle;
                        phase = LS_IDLE;
                        want.accepted = 1'b1;
                    end
                EV_RESET:
                begin
                    clear_link();
                    bump_tag();
                    want.accepted = 1'b1;
                end
                default: ;
            endcase
            want.link_state         = phase;
            want.current_interface  = iface;
            want.current_connection = conn;
            want.current_attempt    = active_tag;
            pending.push_back(want);
            events_noted++;
            if (want.accepted)
                accepted_count++;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(logic [95:0] word);
            result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t ns: result 0x%0h with no item outstanding", $time, word);
                return;
            end
            want = pending.pop_front();
            results_checked++;
            compare_field("accepted", 32'(want.accepted), 32'(word[0]));
            compare_field("open_outcome", 32'(want.open_outcome), 32'(word[2:1]));
            compare_field("issued_attempt", want.issued_attempt, word[34:3]);
            compare_field("link_state", 32'(want.link_state), 32'(word[37:35]));
            compare_field("current_interface", 32'(want.current_interface),
                          32'(word[45:38]));
            compare_field("current_connection", 32'(want.current_connection),
                          32'(word[61:46]));
            compare_field("current_attempt", want.current_attempt, word[93:62]);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // interface_id, attempt_tag, connection_handle
    logic [3:0]  s_tuser = '0;   // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;        // accepted, open_outcome, issued_attempt, link_state,
                                 // current_interface, current_connection,
                                 // current_attempt, zero fill

    link_scoreboard sb;
    int sender_idle = 7;
    int recv_idle = 76;

    gatt_client_link_state_tracker uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
        m_tready = ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    task automatic drive_event(logic [3:0] mode, logic [7:0] id, logic [31:0] tag,
                               logic [15:0] hdl);
        event_t ev;
        ev.mode              = mode;
        ev.interface_id      = id;
        ev.attempt_tag       = tag;
        ev.connection_handle = hdl;
        while ($urandom_range(99) < sender_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tuser  = mode;
        s_tdata  = {hdl, tag, id};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_event(ev);
        @(negedge clk);
    endtask

    // only called with the block drained
    task automatic apply_sentinels(logic [7:0] iface, logic [15:0] handle);
        cfg_we   = 1'b1;
        cfg_addr = CFG_IFACE;
        cfg_data = {8'h00, iface};
        @(posedge clk);
        sb.write_reg(CFG_IFACE, cfg_data);
        @(negedge clk);
        cfg_addr = CFG_HANDLE;
        cfg_data = handle;
        @(posedge clk);
        sb.write_reg(CFG_HANDLE, cfg_data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] skewed_value(logic [15:0] top);
        case ($urandom_range(7))
            0: return '0;
            1: return top;
            default: return 16'($urandom) & top;
        endcase
    endfunction

    // mostly legal traffic for the current state, with some noise and resets
    function automatic event_t pick_event();
        event_t ev;
        int roll;
        roll = $urandom_range(99);
        ev.mode              = EV_RESET;
        ev.interface_id      = 8'($urandom);
        ev.attempt_tag       = $urandom;
        ev.connection_handle = 16'($urandom);
        if (roll < 15)
        begin
            ev.mode = 4'($urandom_range(15));
            case ($urandom_range(3))
                0: ev.attempt_tag = sb.active_tag;
                1: ev.attempt_tag = sb.active_tag ^ (32'd1 << $urandom_range(31));
                default: ;
            endcase
            if ($urandom_range(1))
                ev.connection_handle = sb.conn;
            return ev;
        end
        if (roll < 19)
            return ev;
        ev.attempt_tag       = sb.active_tag;
        ev.connection_handle = sb.conn;
        case (sb.phase)
            LS_UNREG:
                ev.mode = EV_BEGIN_REG;
            LS_REGISTERING:
            begin
                ev.mode = EV_REGISTERED;
                ev.interface_id = 8'(skewed_value(16'h00FF));
            end
            LS_IDLE:
                ev.mode = EV_BEGIN_OPEN;
            LS_OPENING:
            begin
                case ($urandom_range(2))
                    0: ev.mode = EV_BEGIN_CANCEL;
                    1: ev.mode = EV_OPENED;
                    default: ev.mode = EV_OPEN_FAIL;
                endcase
                ev.connection_handle = skewed_value(16'hFFFF);
            end
            LS_CANCELLING:
            begin
                case ($urandom_range(2))
                    0: ev.mode = EV_OPENED;
                    1: ev.mode = EV_OPEN_FAIL;
                    default: ev.mode = EV_CANCELLED;
                endcase
                ev.connection_handle = skewed_value(16'hFFFF);
            end
            LS_CONNECTED:
                ev.mode = $urandom_range(1) ? EV_BEGIN_CLOSE : EV_DISCONNECTED;
            default:
                ev.mode = EV_DISCONNECTED;
        endcase
        return ev;
    endfunction

    initial
    begin
        event_t ev;
        int waited;
        sb = new;
        sb.power_on();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed walk with the reset sentinels
        drive_event(EV_OPENED, 8'h00, 32'h0, 16'h0000);
        drive_event(EV_BEGIN_REG, 8'hFF, 32'hFFFFFFFF, 16'hFFFF);
        drive_event(EV_REGISTERED, 8'hFF, 32'h0, 16'h0000);
        drive_event(EV_REGISTERED, 8'h00, 32'h0, 16'h0000);
        drive_event(EV_BEGIN_OPEN, 8'h00, 32'h0, 16'h0000);
        drive_event(EV_BEGIN_CANCEL, 8'h00, 32'h0, 16'h0000);
        drive_event(EV_BEGIN_CANCEL, 8'h00, 32'hFFFFFFFF, 16'h0000);
        drive_event(EV_BEGIN_CANCEL, 8'h00, sb.active_tag, 16'h0000);
        drive_event(EV_OPENED, 8'h00, sb.active_tag, 16'hFFFF);
        drive_event(EV_OPENED, 8'h00, sb.active_tag, 16'h0000);
        drive_event(EV_DISCONNECTED, 8'h00, 32'h0, 16'h0000);
        drive_event(EV_BEGIN_OPEN, 8'hFF, 32'hFFFFFFFF, 16'hFFFF);
        drive_event(EV_OPEN_FAIL, 8'h00, sb.active_tag, 16'h0000);
        drive_event(EV_BEGIN_OPEN, 8'h00, 32'h0, 16'h0000);
        drive_event(EV_BEGIN_CANCEL, 8'h00, sb.active_tag, 16'h0000);
        drive_event(EV_CANCELLED, 8'h00, sb.active_tag, 16'h0000);
        drive_event(EV_BEGIN_OPEN, 8'h00, 32'h0, 16'h0000);
        drive_event(EV_OPENED, 8'h00, sb.active_tag, 16'hFFFE);
        drive_event(EV_BEGIN_CLOSE, 8'h00, 32'h0, 16'h1234);
        drive_event(EV_BEGIN_CLOSE, 8'h00, 32'h0, 16'hFFFE);
        drive_event(EV_DISCONNECTED, 8'h00, 32'h0, 16'hFFFE);
        drive_event(4'd10, 8'hA5, 32'h5A5A5A5A, 16'hA5A5);
        drive_event(4'd15, 8'hFF, 32'hFFFFFFFF, 16'hFFFF);
        drive_event(EV_RESET, 8'h00, 32'h0, 16'h0000);
        drive_event(EV_BEGIN_REG, 8'h00, 32'h0, 16'h0000);

        for (int seg = 0; seg < 6; seg++)
        begin
            sender_idle = (seg < 2) ? 7 : (seg < 4) ? 76 : 0;
            recv_idle   = (seg < 2) ? 76 : (seg < 4) ? 7 : 0;
            s_tvalid = 1'b0;
            while (sb.pending.size() != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
            case (seg)
                0: apply_sentinels(8'h00, 16'h0000);
                1: apply_sentinels(8'hFF, 16'hFFFF);
                3: apply_sentinels(8'hFF, 16'h0000);
                4: apply_sentinels(8'h00, 16'hFFFF);
                default: apply_sentinels(8'($urandom), 16'($urandom));
            endcase
            repeat (200)
            begin
                ev = pick_event();
                drive_event(ev.mode, ev.interface_id, ev.attempt_tag, ev.connection_handle);
            end
        end
        s_tvalid = 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 2000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (8) @(negedge clk);
        if (sb.pending.size() != 0)
        begin
            sb.errors++;
            $display("%0t ns: %0d results never arrived", $time, sb.pending.size());
        end

        $display("sent %0d events (%0d accepted, %0d connects after cancel), checked %0d results",
                 sb.events_noted, sb.accepted_count, sb.late_connects, sb.results_checked);
        $display("six sentinel settings incl. all-zero and all-ones, three stall profiles");
        if (sb.errors == 0)
            $display("gatt_client_link_state_tracker verification clean");
        else
            $display("gatt_client_link_state_tracker verification failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("watchdog expired at %0t ns", $time);
        $display("gatt_client_link_state_tracker verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/gclst_pkg.sv
rtl/gclst_fsm.sv
rtl/gclst_out_stage.sv
rtl/gatt_client_link_state_tracker.sv
test/tb_gatt_client_link_state_tracker.sv
